// ===== rtl/assert_macros.svh =====
// assertion macros for the checker module
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every edge outside reset
`define LKVC_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lkvc assertion failed");

// antecedent in one cycle implies consequent in the next
`define LKVC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");

`endif

// ===== rtl/lkvc_pkg.sv =====
// shared types and constants for the lru key/value cache
// no dependencies; used by the cache top level and the testbench
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(ENTRIES);
  localparam logic [CAP_W-1:0]  CAP_MAX    = CAP_W'(ENTRIES);
  localparam logic [CAP_W-1:0]  CAP_MIN    = CAP_W'(1);
  localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lkvc_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache.sv =====
// lru key/value cache: an accepted request goes through the lookup state, then the result state raises done
// a new request can be accepted with done in the result state, but start is ignored while busy
// busy is high for the one lookup cycle; the result shows for one cycle with done
// reset empties the store and sets capacity to 16; a capacity write also empties it
// depends on lkvc_pkg and lkvc_ram
`default_nettype none

module lru_key_value_cache (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [4:0]          cfg_data,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                mode,
  input  wire logic signed [31:0]  key,
  input  wire logic signed [31:0]  value,
  output logic                     done,
  output logic                     found,
  output logic signed [31:0]       read_value,
  output logic                     evicted,
  output logic signed [31:0]       evicted_key
);

  lkvc_pkg::state_t state, state_next;

  logic [lkvc_pkg::CAP_W-1:0]  capacity;
  logic [lkvc_pkg::CAP_W-1:0]  eff_cap;

  logic                        op_mode;
  logic [lkvc_pkg::KEY_W-1:0]  op_key;
  logic [lkvc_pkg::DATA_W-1:0] op_value;

  logic [lkvc_pkg::ENTRIES-1:0] valid, valid_next;
  logic [lkvc_pkg::RANK_W-1:0]  rank [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::RANK_W-1:0]  rank_next [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]   keys [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::CNT_W-1:0]   count, count_next, count_dec;

  logic [lkvc_pkg::ENTRIES-1:0] hit_vec, victim_vec, free_vec;
  logic                         hit, full, evict, free_any, lookup;
  logic [lkvc_pkg::IDX_W-1:0]   hit_idx, victim_idx, free_idx;
  logic [lkvc_pkg::RANK_W-1:0]  hit_rank;

  logic                         ram_we;
  logic [lkvc_pkg::IDX_W-1:0]   ram_waddr;
  logic [lkvc_pkg::DATA_W-1:0]  ram_rdata;

  logic                         res_mode, res_found, res_evicted;
  logic [lkvc_pkg::KEY_W-1:0]   res_evicted_key;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkvc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    done       = 1'b0;
    lookup     = 1'b0;
    unique case (state)
      lkvc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = lkvc_pkg::ST_LOOKUP;
        end
      end
      lkvc_pkg::ST_LOOKUP: begin
        busy       = 1'b1;
        lookup     = 1'b1;
        state_next = lkvc_pkg::ST_RESULT;
      end
      lkvc_pkg::ST_RESULT: begin
        done       = 1'b1;
        state_next = start ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
      end
      default: begin
        state_next = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  // capacity register, out of range values are clamped when used
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    if (capacity < lkvc_pkg::CAP_MIN) begin
      eff_cap = lkvc_pkg::CAP_MIN;
    end else if (capacity > lkvc_pkg::CAP_MAX) begin
      eff_cap = lkvc_pkg::CAP_MAX;
    end else begin
      eff_cap = capacity;
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_mode  <= mode;
      op_key   <= lkvc_pkg::KEY_W'(key);
      op_value <= lkvc_pkg::DATA_W'(value);
    end
  end

  // parallel tag compare and victim / free slot search
  assign count_dec = count - lkvc_pkg::CNT_W'(1);
  assign full      = lkvc_pkg::CAP_W'(count) >= eff_cap;

  always_comb begin
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      hit_vec[i]    = valid[i] && (keys[i] == op_key);
      victim_vec[i] = valid[i] && (rank[i] == count_dec[lkvc_pkg::RANK_W-1:0]);
    end
  end

  assign hit   = |hit_vec;
  assign evict = (op_mode == lkvc_pkg::MODE_PUT) && !hit && full;

  // slots free once the victim has left
  assign free_vec = ~(valid & ~(evict ? victim_vec : '0));
  assign free_any = |free_vec;

  always_comb begin
    hit_idx    = '0;
    victim_idx = '0;
    free_idx   = '0;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = lkvc_pkg::IDX_W'(i);
      end
      if (victim_vec[i]) begin
        victim_idx = lkvc_pkg::IDX_W'(i);
      end
    end
    // descending so the lowest free slot wins
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = lkvc_pkg::IDX_W'(i);
      end
    end
  end

  assign hit_rank = rank[hit_idx];

  // recency update
  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      rank_next[i] = rank[i];
    end
    if (lookup) begin
      if (hit) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (valid[i] && (rank[i] < hit_rank)) begin
            rank_next[i] = rank[i] + lkvc_pkg::RANK_W'(1);
          end
        end
        rank_next[hit_idx] = '0;
      end else if (op_mode == lkvc_pkg::MODE_PUT) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (evict && victim_vec[i]) begin
            valid_next[i] = 1'b0;
            rank_next[i]  = '0;
          end else if (valid[i]) begin
            rank_next[i] = rank[i] + lkvc_pkg::RANK_W'(1);
          end
        end
        if (free_any) begin
          valid_next[free_idx] = 1'b1;
          rank_next[free_idx]  = '0;
        end
        count_next = count - lkvc_pkg::CNT_W'(evict) + lkvc_pkg::CNT_W'(free_any);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      valid <= valid_next;
      count <= count_next;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  // key store, written only on insert
  always_ff @(posedge clk) begin
    if (lookup && (op_mode == lkvc_pkg::MODE_PUT) && !hit && free_any) begin
      keys[free_idx] <= op_key;
    end
  end

  // value store: a put writes the hit or new slot, a get reads the hit slot
  assign ram_we    = lookup && (op_mode == lkvc_pkg::MODE_PUT) && (hit || free_any);
  assign ram_waddr = hit ? hit_idx : free_idx;

  lkvc_ram #(
    .WIDTH (lkvc_pkg::DATA_W),
    .DEPTH (lkvc_pkg::ENTRIES)
  ) u_value_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (op_value),
    .raddr (hit_idx),
    .rdata (ram_rdata)
  );

  // result registers, shown in the cycle after the lookup
  always_ff @(posedge clk) begin
    if (lookup) begin
      res_mode        <= op_mode;
      res_found       <= hit;
      res_evicted     <= evict;
      res_evicted_key <= evict ? keys[victim_idx] : '0;
    end
  end

  always_comb begin
    if (res_mode == lkvc_pkg::MODE_PUT) begin
      read_value = '0;
    end else if (res_found) begin
      read_value = ram_rdata;
    end else begin
      read_value = lkvc_pkg::MISS_VALUE;
    end
  end

  assign found       = res_found;
  assign evicted     = res_evicted;
  assign evicted_key = res_evicted_key;

endmodule

`default_nettype wire

// ===== rtl/lkvc_checker.sv =====
// port level checks for the lru key/value cache, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lkvc_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire logic                found,
  input wire logic signed [31:0]  read_value,
  input wire logic                evicted,
  input wire logic signed [31:0]  evicted_key
);

  // an accepted transaction is worked on in the next cycle
  `LKVC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)

  // every lookup cycle is followed by a result strobe with busy low
  `LKVC_ASSERT_NEXT(a_busy_done, clk, rst, busy, done && !busy)

  // an eviction only comes from a put that missed
  `LKVC_ASSERT(a_evict_put_miss, clk, rst, !(done && evicted) || (!found && read_value == 0))

  // no evicted key is reported without an eviction
  `LKVC_ASSERT(a_evict_key_zero, clk, rst, !(done && !evicted) || evicted_key == 0)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .found       (found),
  .read_value  (read_value),
  .evicted     (evicted),
  .evicted_key (evicted_key)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// self-checking testbench for the lru key/value cache: directed and random get/put traffic
// predicts every response with a local lru model and compares it field by field
// depends on lkvc_pkg and the lru_key_value_cache rtl
`default_nettype none

module testbench;

  typedef struct packed {
    logic                        found;
    logic [lkvc_pkg::DATA_W-1:0] read_value;
    logic                        evicted;
    logic [lkvc_pkg::KEY_W-1:0]  evicted_key;
  } cache_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0]  cfg_data = '0;
  logic                        start = 1'b0;
  logic                        mode = lkvc_pkg::MODE_GET;
  logic [lkvc_pkg::KEY_W-1:0]  key = '0;
  logic [lkvc_pkg::DATA_W-1:0] value = '0;
  logic                        busy;
  logic                        done;
  logic                        found;
  logic [lkvc_pkg::DATA_W-1:0] read_value;
  logic                        evicted;
  logic [lkvc_pkg::KEY_W-1:0]  evicted_key;

  // local copy of the cache contents and the capacity register
  logic                        slot_used [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::KEY_W-1:0]  slot_key  [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::DATA_W-1:0] slot_data [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::RANK_W-1:0] slot_age  [lkvc_pkg::ENTRIES];
  int                          used_count;
  logic [lkvc_pkg::CAP_W-1:0]  cap_setting;

  cache_result_t               pending_results[$];
  logic [lkvc_pkg::KEY_W-1:0]  key_pool[$];
  int                          mismatch_count = 0;
  int                          sender_idle_pct = 0;

  lru_key_value_cache DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .mode(mode),
    .key(key),
    .value(value),
    .done(done),
    .found(found),
    .read_value(read_value),
    .evicted(evicted),
    .evicted_key(evicted_key)
  );

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("ERROR at %0t: %s got %h expected %h", $time, what, got, want);
  endtask

  function automatic void clear_store();
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i]  = '0;
      slot_data[i] = '0;
      slot_age[i]  = '0;
    end
    used_count = 0;
  endfunction

  function automatic int cap_limit();
    if (cap_setting == 0) return 1;
    if (cap_setting > lkvc_pkg::ENTRIES) return lkvc_pkg::ENTRIES;
    return int'(cap_setting);
  endfunction

  // entries younger than slot s age by one, s becomes the youngest
  function automatic void make_recent(input int s);
    logic [lkvc_pkg::RANK_W-1:0] r;
    r = slot_age[s];
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = '0;
  endfunction

  function automatic cache_result_t cache_access(input logic m,
                                                 input logic [lkvc_pkg::KEY_W-1:0] k,
                                                 input logic [lkvc_pkg::DATA_W-1:0] v);
    cache_result_t               r;
    int                          hit;
    int                          victim;
    int                          free_slot;
    logic [lkvc_pkg::RANK_W-1:0] oldest;
    r = '0;
    hit = -1;
    for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
      if (hit < 0 && slot_used[i] && slot_key[i] == k) hit = i;
    if (m == lkvc_pkg::MODE_GET) begin
      if (hit >= 0) begin
        r.found = 1'b1;
        r.read_value = slot_data[hit];
        make_recent(hit);
      end else begin
        r.read_value = lkvc_pkg::MISS_VALUE;
      end
    end else if (hit >= 0) begin
      r.found = 1'b1;
      slot_data[hit] = v;
      make_recent(hit);
    end else begin
      // full store: drop the oldest entry before placing the new one
      if (used_count >= cap_limit()) begin
        victim = -1;
        oldest = '0;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
          if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
            victim = i;
            oldest = slot_age[i];
          end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[victim];
          slot_used[victim] = 1'b0;
          slot_age[victim] = '0;
          if (used_count > 0) used_count--;
        end
      end
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        if (slot_used[i]) slot_age[i]++;
      free_slot = -1;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
        if (free_slot < 0 && !slot_used[i]) free_slot = i;
      if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot]  = k;
        slot_data[free_slot] = v;
        slot_age[free_slot]  = '0;
        used_count++;
      end
    end
    return r;
  endfunction

  // one transaction; start stays high only if the next call follows at once
  task automatic issue_request(input logic m, input logic [lkvc_pkg::KEY_W-1:0] k,
                               input logic [lkvc_pkg::DATA_W-1:0] v);
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(cache_access(m, k, v));
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    int n;
    start <= 1'b0;
    n = 0;
    while (pending_results.size() != 0 && n < 1000) begin
      @(posedge clk);
      n++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch("responses never arrived", pending_results.size(), 0);
      pending_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // only called with the cache idle; a write also empties the store
  task automatic set_capacity(input logic [lkvc_pkg::CAP_W-1:0] c);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_setting = c;
    clear_store();
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("response with no transaction pending", read_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) report_mismatch("found", 32'(found), 32'(want.found));
        if (read_value !== want.read_value)
          report_mismatch("read_value", read_value, want.read_value);
        if (evicted !== want.evicted)
          report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
        if (evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", evicted_key, want.evicted_key);
      end
    end
  end

  task automatic test_basic_get_put();
    sender_idle_pct = 0;
    issue_request(lkvc_pkg::MODE_GET, 32'h0000_0000, 32'h1234_5678);
    issue_request(lkvc_pkg::MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
    issue_request(lkvc_pkg::MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
    issue_request(lkvc_pkg::MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
    issue_request(lkvc_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0000);
    issue_request(lkvc_pkg::MODE_GET, 32'h8000_0000, 32'h0);
    issue_request(lkvc_pkg::MODE_GET, 32'h7fff_ffff, 32'hffff_ffff);
    issue_request(lkvc_pkg::MODE_GET, 32'hffff_ffff, 32'h0);
    issue_request(lkvc_pkg::MODE_GET, 32'h0000_0000, 32'h0);
    issue_request(lkvc_pkg::MODE_GET, 32'h0000_0001, 32'h0);
    // put that hits updates in place, no eviction
    issue_request(lkvc_pkg::MODE_PUT, 32'hffff_ffff, 32'h0000_0005);
    issue_request(lkvc_pkg::MODE_GET, 32'hffff_ffff, 32'h0);
    wait_drained();
  endtask

  task automatic test_lru_eviction();
    set_capacity(5'd2);
    issue_request(lkvc_pkg::MODE_PUT, 32'h0000_00aa, 32'h0000_0001);
    issue_request(lkvc_pkg::MODE_PUT, 32'h0000_00bb, 32'h0000_0002);
    issue_request(lkvc_pkg::MODE_GET, 32'h0000_00aa, 32'h0);
    issue_request(lkvc_pkg::MODE_PUT, 32'h0000_00cc, 32'h0000_0003);
    issue_request(lkvc_pkg::MODE_GET, 32'h0000_00bb, 32'h0);
    issue_request(lkvc_pkg::MODE_PUT, 32'h0000_00aa, 32'h0000_0004);
    wait_drained();
  endtask

  task automatic test_capacity_clamp();
    // zero behaves as a single entry
    set_capacity(5'd0);
    issue_request(lkvc_pkg::MODE_PUT, 32'h0000_0011, 32'h5555_5555);
    issue_request(lkvc_pkg::MODE_PUT, 32'h0000_0022, 32'haaaa_aaaa);
    issue_request(lkvc_pkg::MODE_GET, 32'h0000_0011, 32'h0);
    issue_request(lkvc_pkg::MODE_GET, 32'h0000_0022, 32'h0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input logic [lkvc_pkg::CAP_W-1:0] cap,
                                     input int idle_pct, input int count,
                                     input int drain_every);
    logic [lkvc_pkg::KEY_W-1:0] k;
    int                         pool_size;
    set_capacity(cap);
    sender_idle_pct = idle_pct;
    // pool a bit larger than the capacity so hits and evictions both happen
    pool_size = cap_limit() + 4;
    key_pool.delete();
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h7fff_ffff);
    for (int i = 2; i < pool_size; i++) key_pool.push_back($urandom);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(key_pool.size() - 1)];
      issue_request($urandom_range(1) ? lkvc_pkg::MODE_PUT : lkvc_pkg::MODE_GET, k,
                    $urandom);
      if (drain_every > 0 && (n % drain_every) == drain_every - 1) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    clear_store();
    cap_setting = lkvc_pkg::CAP_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_basic_get_put();
    test_lru_eviction();
    test_capacity_clamp();
    test_random_traffic(5'd16, 0, 250, 0);
    test_random_traffic(5'd1, 79, 200, 0);
    test_random_traffic(5'd31, 0, 250, 40);
    test_random_traffic(5'd0, 32, 200, 0);
    test_random_traffic(lkvc_pkg::CAP_W'($urandom_range(2, 15)), 32, 300, 0);
    test_random_traffic(5'd16, 79, 300, 0);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/lkvc_pkg.sv
rtl/lkvc_ram.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
dv/testbench.sv
